FILE: src/smst_pkg.sv
// Package for the sorted integer multiset table.
// Holds the sequencer state type and the key compare result type; no dependencies.
package smst_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LB_RD,
    ST_LB_CMP,
    ST_UB_RD,
    ST_UB_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_PUT,
    ST_RESP
  } seq_state_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: src/sorted_int_multiset_table_unit.sv
// Sorted integer multiset table: sequencer, key memory and shared comparator.
// Each request runs a lower-bound and an upper-bound binary search over the n entries, then
// a response; an insert also moves the entries from its position upward by one and stores the key.
// Throughput: one request at a time; the next is taken from the cycle the response appears.
// Reset (synchronous, active low) empties the table; memory contents are left as they are.
module sorted_int_multiset_table_unit
  import smst_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [31:0] in_key,
  input  logic               in_unique_only,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [8:0]         out_position,
  output logic [8:0]         out_match_count,
  output logic               out_inserted,
  output logic               out_table_full,
  output logic [8:0]         out_entries_now
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  seq_state_t state_r, state_nxt;

  logic signed [31:0] key_r, key_nxt;
  logic               ins_r, ins_nxt;
  logic               uniq_r, uniq_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [CW-1:0]      mid_r, mid_nxt;
  logic [CW-1:0]      lb_r, lb_nxt;
  logic [CW-1:0]      mc_r, mc_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               ins_done_r, ins_done_nxt;
  logic               full_r, full_nxt;

  logic               out_valid_r;
  logic               out_found_r;
  logic [8:0]         out_position_r;
  logic [8:0]         out_match_count_r;
  logic               out_inserted_r;
  logic               out_table_full_r;
  logic [8:0]         out_entries_now_r;

  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      idx_m1;
  logic [CW-1:0]      span;
  logic               dup;
  logic               room;
  logic               do_ins;
  logic               out_free;
  logic [CW+8:0]      pos_ext;
  logic [CW+8:0]      mc_ext;
  logic [CW+8:0]      cnt_ext;

  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic signed [31:0] mem_wr_data;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic signed [31:0] mem_rd_data;
  cmp_res_t           cmp;

  smst_keystore #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  smst_compare u_cmp (
    .stored_key (mem_rd_data),
    .probe_key  (key_r),
    .res        (cmp)
  );

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CW:1];
  assign idx_m1   = idx_r - 1'b1;
  assign span     = lo_r - lb_r;
  assign dup      = uniq_r && (span != '0);
  assign room     = count_r != CW'(CAPACITY);
  assign do_ins   = ins_r && !dup && room;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = state_r == ST_IDLE;

  assign pos_ext = {9'd0, lb_r};
  assign mc_ext  = {9'd0, mc_r};
  assign cnt_ext = {9'd0, count_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LB_RD;
        end
      end
      ST_LB_RD: begin
        state_nxt = (lo_r < hi_r) ? ST_LB_CMP : ST_UB_RD;
      end
      ST_LB_CMP: begin
        state_nxt = ST_LB_RD;
      end
      ST_UB_RD: begin
        if (lo_r < hi_r) begin
          state_nxt = ST_UB_CMP;
        end else begin
          state_nxt = do_ins ? ST_SH_RD : ST_RESP;
        end
      end
      ST_UB_CMP: begin
        state_nxt = ST_UB_RD;
      end
      ST_SH_RD: begin
        state_nxt = (idx_r > lb_r) ? ST_SH_WR : ST_PUT;
      end
      ST_SH_WR: begin
        state_nxt = ST_SH_RD;
      end
      ST_PUT: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    key_nxt      = key_r;
    ins_nxt      = ins_r;
    uniq_nxt     = uniq_r;
    count_nxt    = count_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    lb_nxt       = lb_r;
    mc_nxt       = mc_r;
    idx_nxt      = idx_r;
    ins_done_nxt = ins_done_r;
    full_nxt     = full_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = idx_r[AW-1:0];
    mem_wr_data  = mem_rd_data;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = mid[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt      = in_key;
          ins_nxt      = in_action;
          uniq_nxt     = in_unique_only;
          lo_nxt       = '0;
          hi_nxt       = count_r;
          ins_done_nxt = 1'b0;
          full_nxt     = 1'b0;
        end
      end
      ST_LB_RD: begin
        if (lo_r < hi_r) begin
          mem_rd_en = 1'b1;
          mid_nxt   = mid;
        end else begin
          lb_nxt = lo_r;
          hi_nxt = count_r;
        end
      end
      ST_LB_CMP: begin
        if (cmp.lt) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
      end
      ST_UB_RD: begin
        if (lo_r < hi_r) begin
          mem_rd_en = 1'b1;
          mid_nxt   = mid;
        end else begin
          mc_nxt   = span;
          idx_nxt  = count_r;
          full_nxt = ins_r && !dup && !room;
        end
      end
      ST_UB_CMP: begin
        if (cmp.lt || cmp.eq) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
      end
      ST_SH_RD: begin
        if (idx_r > lb_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_m1[AW-1:0];
        end
      end
      ST_SH_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r[AW-1:0];
        mem_wr_data = mem_rd_data;
        idx_nxt     = idx_m1;
      end
      ST_PUT: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = lb_r[AW-1:0];
        mem_wr_data  = key_r;
        count_nxt    = count_r + 1'b1;
        ins_done_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    ins_r      <= ins_nxt;
    uniq_r     <= uniq_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    lb_r       <= lb_nxt;
    mc_r       <= mc_nxt;
    idx_r      <= idx_nxt;
    ins_done_r <= ins_done_nxt;
    full_r     <= full_nxt;
    if (state_r == ST_RESP && out_free) begin
      out_found_r       <= mc_r != '0;
      out_position_r    <= pos_ext[8:0];
      out_match_count_r <= mc_ext[8:0];
      out_inserted_r    <= ins_done_r;
      out_table_full_r  <= full_r;
      out_entries_now_r <= cnt_ext[8:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_position    = out_position_r;
  assign out_match_count = out_match_count_r;
  assign out_inserted    = out_inserted_r;
  assign out_table_full  = out_table_full_r;
  assign out_entries_now = out_entries_now_r;

endmodule

FILE: src/smst_compare.sv
// Shared signed key comparator of the sorted integer multiset table.
// Depends on smst_pkg for the compare result type.
module smst_compare
  import smst_pkg::*;
(
  input  logic signed [31:0] stored_key,
  input  logic signed [31:0] probe_key,
  output cmp_res_t           res
);

  assign res.lt = stored_key < probe_key;
  assign res.eq = stored_key == probe_key;

endmodule

FILE: src/smst_keystore.sv
// Key memory of the sorted integer multiset table: one write and one read port.
// The read data is registered; no package dependencies.
module smst_keystore #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [31:0]  wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic signed [31:0]  rd_data
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/smst_checker.sv
// Port-level checker for the sorted integer multiset table, bound to the top level.
// Depends only on the top level's ports.
module smst_checker #(
  parameter int CAPACITY = 256
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_found,
  input logic [8:0]         out_position,
  input logic [8:0]         out_match_count,
  input logic               out_inserted,
  input logic               out_table_full,
  input logic [8:0]         out_entries_now
);

  localparam logic [31:0] CapWord = 32'(CAPACITY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) && $stable(out_entries_now))
    else $error("Stalled response changed");

  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_found == (out_match_count != 9'd0))
    else $error("Found flag disagrees with match count");

  a_ins_excl_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inserted |-> !out_table_full && out_entries_now != 9'd0)
    else $error("Insert reported together with full table");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_entries_now == CapWord[8:0])
    else $error("Full table reported below capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request taken while another is in progress");

endmodule

bind sorted_int_multiset_table_unit smst_checker #(.CAPACITY(CAPACITY)) u_smst_checker (.*);

FILE: bench/sorted_int_multiset_table_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_int_multiset_table_unit: directed and random lookups and
// inserts, with a scoreboard class that keeps its own sorted copy of the table.
// Depends only on the RTL of the unit.
module sorted_int_multiset_table_unit_test;

  localparam int CAPACITY = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_REQUESTS = 1430;
  localparam int QUIET_TAIL = 200;
  localparam int MAX_REPORTS = 10;
  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_INSERT = 1'b1;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic       found;
    logic [8:0] position;
    logic [8:0] match_count;
    logic       inserted;
    logic       table_full;
    logic [8:0] entries_now;
  } lookup_t;

  class table_scoreboard;
    logic signed [31:0] keys [CAPACITY];
    int stored = 0;
    int mismatches = 0;
    lookup_t expected_q[$];

    function void note_request(logic action, logic signed [31:0] key, logic uniq);
      lookup_t r;
      int lb;
      int cnt;
      int i;
      lb = 0;
      cnt = 0;
      while (lb < stored && keys[lb] < key) lb++;
      while (lb + cnt < stored && keys[lb + cnt] == key) cnt++;
      r = '0;
      r.found = (cnt != 0);
      r.position = lb[8:0];
      r.match_count = cnt[8:0];
      if (action == ACT_INSERT && !(uniq && r.found)) begin
        if (stored >= CAPACITY) begin
          r.table_full = 1'b1;
        end else begin
          for (i = stored; i > lb; i--) keys[i] = keys[i - 1];
          keys[lb] = key;
          stored++;
          r.inserted = 1'b1;
        end
      end
      r.entries_now = stored[8:0];
      expected_q.push_back(r);
    endfunction

    function void report(string what, lookup_t want, lookup_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t %s: expected found=%0d pos=%0d cnt=%0d ins=%0d full=%0d n=%0d,",
                 $time, what, want.found, want.position, want.match_count, want.inserted,
                 want.table_full, want.entries_now);
        $display("  got found=%0d pos=%0d cnt=%0d ins=%0d full=%0d n=%0d",
                 got.found, got.position, got.match_count, got.inserted,
                 got.table_full, got.entries_now);
      end
    endfunction

    function void check_response(lookup_t got);
      lookup_t want;
      if (expected_q.size() == 0) begin
        report("Response without a pending request", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.found !== want.found || got.position !== want.position ||
            got.match_count !== want.match_count || got.inserted !== want.inserted ||
            got.table_full !== want.table_full || got.entries_now !== want.entries_now)
          report("Response mismatch", want, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_action;
  logic signed [31:0] in_key;
  logic               in_unique_only;
  logic               out_valid;
  logic               out_ready;
  logic               out_found;
  logic [8:0]         out_position;
  logic [8:0]         out_match_count;
  logic               out_inserted;
  logic               out_table_full;
  logic [8:0]         out_entries_now;

  table_scoreboard sb;
  bit quiet;
  int stall_cycles;

  sorted_int_multiset_table_unit #(.CAPACITY(CAPACITY)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_unique_only  (in_unique_only),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_match_count (out_match_count),
    .out_inserted    (out_inserted),
    .out_table_full  (out_table_full),
    .out_entries_now (out_entries_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(input logic action, input logic signed [31:0] key,
                              input logic uniq);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_key <= key;
    in_unique_only <= uniq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(action, key, uniq);
  endtask

  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    k = $urandom;
    case ($urandom_range(0, 9))
      0: k = KEY_MIN;
      1: k = KEY_MAX;
      2: begin
        k = $urandom_range(0, 16);
        k = k - 8;
      end
      3, 4, 5: if (sb.stored != 0) k = sb.keys[$urandom_range(0, sb.stored - 1)];
      6: if (sb.stored != 0) begin
        k = sb.keys[$urandom_range(0, sb.stored - 1)];
        k = $urandom_range(0, 1) ? k + 1 : k - 1;
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 48)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_response({out_found, out_position, out_match_count, out_inserted,
                         out_table_full, out_entries_now});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles = 0;
    else
      stall_cycles = stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no request or response moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic action;
    int n;
    sb = new;
    quiet = 1'b0;
    stall_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_QUERY;
    in_key <= '0;
    in_unique_only <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, extremes, duplicates with and without the unique flag.
    send_request(ACT_QUERY, KEY_MIN, 1'b0);
    send_request(ACT_QUERY, KEY_MAX, 1'b1);
    send_request(ACT_INSERT, 32'sd0, 1'b1);
    send_request(ACT_INSERT, KEY_MIN, 1'b0);
    send_request(ACT_INSERT, KEY_MAX, 1'b1);
    send_request(ACT_INSERT, -32'sd1, 1'b0);
    send_request(ACT_INSERT, 32'sd1, 1'b0);
    send_request(ACT_INSERT, 32'sd0, 1'b0);
    send_request(ACT_INSERT, 32'sd0, 1'b1);
    send_request(ACT_QUERY, 32'sd0, 1'b0);
    send_request(ACT_QUERY, 32'sd0, 1'b1);
    send_request(ACT_QUERY, -32'sd2, 1'b0);
    send_request(ACT_QUERY, KEY_MIN, 1'b0);
    send_request(ACT_QUERY, KEY_MAX, 1'b0);
    send_request(ACT_INSERT, KEY_MAX, 1'b0);
    send_request(ACT_QUERY, KEY_MAX, 1'b0);
    send_request(ACT_INSERT, KEY_MIN, 1'b1);
    send_request(ACT_INSERT, 32'sh5555_aaaa, 1'b0);
    send_request(ACT_QUERY, 32'sh2aaa_5555, 1'b1);

    // The table fills up early, so most of the random part runs against a full table.
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      quiet = (n >= RANDOM_REQUESTS - QUIET_TAIL);
      if (sb.stored < CAPACITY)
        action = ($urandom_range(0, 9) < 7) ? ACT_INSERT : ACT_QUERY;
      else
        action = $urandom_range(0, 1) ? ACT_INSERT : ACT_QUERY;
      send_request(action, pick_key(), 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
